[hdl/osc_pkg.sv]
// Shared types and constants for the ordered set successor core.
// No dependencies.
package osc_pkg;

    localparam int KEY_W = 32;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic eq;
        logic better;
    } t_cmp_res;

endpackage

[hdl/osc_key_mem.sv]
// Key table: one write port, one read port, registered read data.
// Depends on osc_pkg.
module osc_key_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [osc_pkg::KEY_W-1:0]   i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [osc_pkg::KEY_W-1:0]   o_rdata
);

    logic [osc_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [osc_pkg::KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/osc_cmp_unit.sv]
// Shared compare unit: equality and successor-candidate test on one entry.
// Depends on osc_pkg.
module osc_cmp_unit (
    input  logic signed [osc_pkg::KEY_W-1:0] i_entry,
    input  logic signed [osc_pkg::KEY_W-1:0] i_key,
    input  logic signed [osc_pkg::KEY_W-1:0] i_best,
    input  logic                             i_have,
    output osc_pkg::t_cmp_res                o_res
);

    always_comb begin
        o_res.eq     = (i_entry == i_key);
        o_res.better = (i_entry > i_key) && (!i_have || (i_entry < i_best));
    end

endmodule

[hdl/ordered_set_successor_core.sv]
// A request is accepted only in the idle state, once the previous one is finished; the key
// table is scanned one entry per cycle through a single read port and compare unit.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, active low) empties the set; the table is not cleared.
// Top level; depends on osc_pkg, osc_key_mem, osc_cmp_unit.
module ordered_set_successor_core #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // key
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // successor
    output logic [2:0]  m_axis_tuser    // status[1:0], found[2]
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    t_state                           r_state, n_state;
    osc_pkg::t_req                    r_type, n_type;
    logic signed [osc_pkg::KEY_W-1:0] r_key, n_key;
    logic [CNT_W-1:0]                 r_idx, n_idx;
    logic                             r_rd_vld, n_rd_vld;
    logic                             r_dup, n_dup;
    logic                             r_have, n_have;
    logic signed [osc_pkg::KEY_W-1:0] r_best, n_best;
    logic [CNT_W-1:0]                 r_count, n_count;
    logic                             r_out_valid, n_out_valid;
    osc_pkg::t_status                 r_out_status, n_out_status;
    logic                             r_out_found, n_out_found;
    logic signed [osc_pkg::KEY_W-1:0] r_out_succ, n_out_succ;

    logic                             w_rd_en;
    logic                             w_we;
    logic                             w_out_free;
    logic                             w_full;
    logic [osc_pkg::KEY_W-1:0]        w_rdata;
    osc_pkg::t_cmp_res                w_cmp;

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_rd_en    = (r_state == S_SCAN) && (r_idx != r_count);
    assign w_we       = (r_state == S_FINISH) && w_out_free && (r_type == osc_pkg::REQ_INSERT)
                        && !r_dup && !w_full;

    osc_key_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_key),
        .i_re    (w_rd_en),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    osc_cmp_unit u_cmp (
        .i_entry (w_rdata),
        .i_key   (r_key),
        .i_best  (r_best),
        .i_have  (r_have),
        .o_res   (w_cmp)
    );

    always_comb begin
        n_state      = r_state;
        n_type       = r_type;
        n_key        = r_key;
        n_idx        = r_idx;
        n_rd_vld     = 1'b0;
        n_dup        = r_dup;
        n_have       = r_have;
        n_best       = r_best;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_succ   = r_out_succ;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_type  = osc_pkg::t_req'(s_axis_tuser);
                    n_key   = s_axis_tdata;
                    n_idx   = '0;
                    n_dup   = 1'b0;
                    n_have  = 1'b0;
                    n_best  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_rd_en) begin
                    n_idx    = r_idx + CNT_W'(1);
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    if (w_cmp.eq) begin
                        n_dup = 1'b1;
                    end
                    if (w_cmp.better) begin
                        n_best = w_rdata;
                        n_have = 1'b1;
                    end
                end else if (!w_rd_en) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_type == osc_pkg::REQ_QUERY) begin
                        n_out_status = osc_pkg::ST_OK;
                        n_out_found  = r_have;
                        n_out_succ   = r_have ? r_best : '0;
                    end else begin
                        n_out_found = 1'b0;
                        n_out_succ  = '0;
                        if (r_dup) begin
                            n_out_status = osc_pkg::ST_DUP;
                        end else if (w_full) begin
                            n_out_status = osc_pkg::ST_FULL;
                        end else begin
                            n_out_status = osc_pkg::ST_OK;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_vld    <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_vld    <= n_rd_vld;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_type       <= n_type;
        r_key        <= n_key;
        r_idx        <= n_idx;
        r_dup        <= n_dup;
        r_have       <= n_have;
        r_best       <= n_best;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_succ   <= n_out_succ;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_succ;
    assign m_axis_tuser  = {r_out_found, r_out_status};

endmodule

[hdl/osc_checker.sv]
// Port-level checks for ordered_set_successor_core, bound to the top level.
// Depends on osc_pkg.
module osc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic [1:0] r_open;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = m_axis_tvalid && m_axis_tready;

    // transactions accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= r_open + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_open != 2'd0)
        else $error("result without a pending request");

    a_zero_when_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata == 32'd0)
        else $error("successor nonzero without found");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == osc_pkg::ST_OK)
        else $error("found with non-ok status");

endmodule

bind ordered_set_successor_core osc_checker u_osc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[verif/tb_top.sv]
// Self-checking testbench for ordered_set_successor_core: a queue-based model
// of the key set predicts every response, and a monitor checks each one.
// Depends on osc_pkg and the ordered_set_successor_core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 64;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;

    typedef struct {
        osc_pkg::t_status    status;
        logic                found;
        logic signed [31:0]  successor;
    } t_response;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // key
    logic        s_axis_tuser = 1'b0; // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // successor
    logic [2:0]  m_axis_tuser;        // status[1:0], found[2]

    ordered_set_successor_core #(
        .CAPACITY(TABLE_DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic signed [31:0] set_keys[$];
    t_response          pending_responses[$];

    int  error_count = 0;
    bit  tx_idle_on = 1'b0;
    bit  rx_idle_on = 1'b0;
    int  rx_hold_cycles = 0;

    int  n_requests = 0;
    int  n_stored = 0;
    int  n_dup = 0;
    int  n_dropped = 0;
    int  n_hit = 0;
    int  n_miss = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(8ns * 1_000_000);
        $display("ordered_set_successor_core regression: fail");
        $finish;
    end

    // Model of the set: insert unless present or full; query the least key above bound.
    function automatic t_response predict_set_response(osc_pkg::t_req kind,
                                                       logic signed [31:0] key);
        t_response r;
        bit        present;
        r.status = osc_pkg::ST_OK;
        r.found = 1'b0;
        r.successor = '0;
        present = 1'b0;
        if (kind == osc_pkg::REQ_INSERT) begin
            foreach (set_keys[i]) begin
                if (set_keys[i] == key) present = 1'b1;
            end
            if (present) begin
                r.status = osc_pkg::ST_DUP;
            end else if (set_keys.size() >= TABLE_DEPTH) begin
                r.status = osc_pkg::ST_FULL;
            end else begin
                set_keys.push_back(key);
            end
        end else begin
            foreach (set_keys[i]) begin
                if (set_keys[i] > key && (!r.found || set_keys[i] < r.successor)) begin
                    r.successor = set_keys[i];
                    r.found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic send_request(osc_pkg::t_req kind, logic [31:0] key);
        t_response r;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = predict_set_response(kind, key);
        pending_responses.push_back(r);
        n_requests++;
        if (kind == osc_pkg::REQ_INSERT) begin
            case (r.status)
                osc_pkg::ST_OK:  n_stored++;
                osc_pkg::ST_DUP: n_dup++;
                default:         n_dropped++;
            endcase
        end else if (r.found) begin
            n_hit++;
        end else begin
            n_miss++;
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        logic signed [31:0] k;
        case ($urandom_range(0, 9))
            0, 1, 2: k = $urandom;
            3, 4, 5: begin
                if (set_keys.size() == 0) begin
                    k = $urandom;
                end else begin
                    k = set_keys[$urandom_range(0, set_keys.size() - 1)];
                    case ($urandom_range(0, 2))
                        0:       k = k - 1;
                        1:       k = k + 1;
                        default: ;
                    endcase
                end
            end
            6, 7: k = $signed($urandom_range(0, 40)) - 20;
            8:    k = 32'h8000_0000 + $urandom_range(0, 3);
            default: k = 32'h7FFF_FFFF - $urandom_range(0, 3);
        endcase
        return k;
    endfunction

    task automatic run_random(int count, int insert_weight, bit vary_idle);
        osc_pkg::t_req kind;
        for (int n = 0; n < count; n++) begin
            if (vary_idle && n % 50 == 0) begin
                tx_idle_on = $urandom_range(0, 2) != 0;
                rx_idle_on = $urandom_range(0, 2) != 0;
            end
            kind = ($urandom_range(0, 99) < insert_weight) ? osc_pkg::REQ_INSERT
                                                           : osc_pkg::REQ_QUERY;
            send_request(kind, pick_key());
        end
    endtask

    // Response acceptance side: random stalls plus an optional long hold.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_response want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_responses.size() == 0) begin
                error_count++;
                $display("%0t: unexpected response status=%0d found=%0b succ=%0d",
                         $realtime, m_axis_tuser[1:0], m_axis_tuser[2],
                         $signed(m_axis_tdata));
            end else begin
                want = pending_responses.pop_front();
                if (m_axis_tuser[1:0] !== want.status || m_axis_tuser[2] !== want.found ||
                    m_axis_tdata !== want.successor) begin
                    error_count++;
                    $display({"%0t: mismatch expected status=%0d found=%0b succ=%0d,",
                              " got status=%0d found=%0b succ=%0d"},
                             $realtime, want.status, want.found, want.successor,
                             m_axis_tuser[1:0], m_axis_tuser[2], $signed(m_axis_tdata));
                end
            end
        end
    end

    task automatic test_empty_set();
        send_request(osc_pkg::REQ_QUERY, 32'h8000_0000);
        send_request(osc_pkg::REQ_QUERY, 32'h0000_0000);
        send_request(osc_pkg::REQ_QUERY, 32'h7FFF_FFFF);
        wait_idle();
    endtask

    task automatic test_signed_extremes();
        send_request(osc_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        send_request(osc_pkg::REQ_INSERT, 32'h8000_0000);
        send_request(osc_pkg::REQ_INSERT, 32'h0000_0000);
        send_request(osc_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        send_request(osc_pkg::REQ_INSERT, 32'h0000_0001);
        send_request(osc_pkg::REQ_QUERY, 32'h7FFF_FFFF);
        send_request(osc_pkg::REQ_QUERY, 32'h7FFF_FFFE);
        send_request(osc_pkg::REQ_QUERY, 32'h8000_0000);
        send_request(osc_pkg::REQ_QUERY, 32'hFFFF_FFFE);
        send_request(osc_pkg::REQ_QUERY, 32'hFFFF_FFFF);
        send_request(osc_pkg::REQ_QUERY, 32'h0000_0000);
        send_request(osc_pkg::REQ_QUERY, 32'h0000_0001);
        wait_idle();
    endtask

    task automatic test_duplicates();
        send_request(osc_pkg::REQ_INSERT, 32'h0000_0000);
        send_request(osc_pkg::REQ_INSERT, 32'h7FFF_FFFF);
        send_request(osc_pkg::REQ_INSERT, 32'h8000_0000);
        send_request(osc_pkg::REQ_INSERT, 32'hAAAA_5555);
        send_request(osc_pkg::REQ_INSERT, 32'hAAAA_5555);
        send_request(osc_pkg::REQ_QUERY, 32'hAAAA_5554);
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_cycles = 400;
        for (int n = 0; n < 12; n++)
            send_request((n % 3 == 0) ? osc_pkg::REQ_INSERT : osc_pkg::REQ_QUERY, pick_key());
        wait_idle();
    endtask

    task automatic test_random_growth();
        run_random(600, 12, 1'b1);
        wait_idle();
    endtask

    task automatic test_full_table();
        logic signed [31:0] fresh;
        while (set_keys.size() < TABLE_DEPTH) send_request(osc_pkg::REQ_INSERT, $urandom);
        do fresh = $urandom; while (fresh inside {set_keys});
        send_request(osc_pkg::REQ_INSERT, fresh);
        send_request(osc_pkg::REQ_INSERT, set_keys[0]);
        send_request(osc_pkg::REQ_INSERT, set_keys[TABLE_DEPTH - 1]);
        send_request(osc_pkg::REQ_QUERY, fresh);
        send_request(osc_pkg::REQ_QUERY, 32'h8000_0000);
        wait_idle();
    endtask

    task automatic test_random_full();
        run_random(300, 50, 1'b1);
        wait_idle();
    endtask

    task automatic test_no_idle();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random(120, 30, 1'b0);
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_empty_set();
        test_signed_extremes();
        test_duplicates();
        test_backpressure();
        test_random_growth();
        test_full_table();
        test_random_full();
        test_no_idle();
        if (pending_responses.size() != 0) begin
            error_count++;
            $display("%0t: %0d responses never arrived", $realtime, pending_responses.size());
        end
        $display("Ran %0d requests: %0d inserts stored, %0d duplicates, %0d dropped on full set",
                 n_requests, n_stored, n_dup, n_dropped);
        $display("Queries: %0d with a successor, %0d without; %0d keys held at end",
                 n_hit, n_miss, set_keys.size());
        if (error_count == 0) begin
            $display("ordered_set_successor_core regression: pass");
        end else begin
            $display("ordered_set_successor_core regression: fail");
        end
        $finish;
    end
endmodule
